// ----- hdl/fba_pkg.sv -----
// Package with the shared types, constants and helpers of the frame bitmap allocator.
`default_nettype none

package fba_pkg;

  // Sizing of the managed memory. FRAME_BYTES and BITS_PER_WORD are powers of two.
  localparam int FRAME_COUNT   = 65536;
  localparam int FRAME_BYTES   = 4096;
  localparam int BITS_PER_WORD = 8;

  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 17;
  localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
  localparam int AIDX_W     = ADDR_W - FRAME_SHIFT;
  localparam int MAP_WORDS  = (FRAME_COUNT + BITS_PER_WORD - 1) / BITS_PER_WORD;
  localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W      = $clog2(BITS_PER_WORD);
  localparam int FIDX_W     = WORD_AW + BIT_W;

  typedef logic [BITS_PER_WORD-1:0] word_t;
  typedef logic [WORD_AW-1:0]       waddr_t;
  typedef logic [BIT_W-1:0]         bitpos_t;
  typedef logic [FIDX_W-1:0]        fidx_t;
  typedef logic [COUNT_W-1:0]       count_t;

  localparam logic [AIDX_W:0] FRAME_LIMIT   = (AIDX_W + 1)'(FRAME_COUNT);
  localparam waddr_t          LAST_WORD     = WORD_AW'(MAP_WORDS - 1);
  localparam word_t           WORD_ALL_USED = '1;
  localparam count_t          COUNT_RESET   = COUNT_W'(FRAME_COUNT);

  // Request kinds.
  typedef enum logic [1:0] {
    REQ_TEST    = 2'd0,
    REQ_RESERVE = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_FIND    = 2'd3
  } req_kind_t;

  // Write and read commands to the bitmap memory.
  typedef struct packed {
    logic   en;
    waddr_t addr;
    word_t  data;
  } ram_wr_t;

  typedef struct packed {
    logic   en;
    waddr_t addr;
  } ram_rd_t;

  typedef struct packed {
    logic    hit;
    bitpos_t pos;
  } free_hit_t;

  // Lowest clear bit of a bitmap word at or above a starting bit position.
  function automatic free_hit_t first_free(input word_t w, input bitpos_t low);
    free_hit_t r;
    r.hit = 1'b0;
    r.pos = '0;
    for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
      if (!w[i] && (BIT_W'(i) >= low)) begin
        r.hit = 1'b1;
        r.pos = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/fba_if.sv -----
// Request and response channel interfaces of the frame bitmap allocator.
`default_nettype none

interface fba_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [fba_pkg::ADDR_W-1:0]  request_address;

  modport source (output valid, output req_type, output request_address, input ready);
  modport sink   (input valid, input req_type, input request_address, output ready);
endinterface

interface fba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         frame_used;
  logic                         found;
  logic [fba_pkg::ADDR_W-1:0]   free_address;
  logic [fba_pkg::COUNT_W-1:0]  used_count;
  logic                         out_of_range;

  modport source (output valid, output frame_used, output found, output free_address,
                  output used_count, output out_of_range, input ready);
  modport sink   (input valid, input frame_used, input found, input free_address,
                  input used_count, input out_of_range, output ready);
endinterface

`default_nettype wire

// ----- hdl/fba_map_ram.sv -----
// Bitmap memory: one write port and one registered read port.
`default_nettype none

module fba_map_ram (
  input  wire                    clk,
  input  wire fba_pkg::ram_wr_t  wr,
  input  wire fba_pkg::ram_rd_t  rd,
  output fba_pkg::word_t         rd_data
);

  fba_pkg::word_t mem [fba_pkg::MAP_WORDS];
  fba_pkg::word_t rd_data_r;

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hdl/fba_ctrl.sv -----
// Sequencer: clearing pass, read-modify-write of marks, word-by-word free search.
`default_nettype none

module fba_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  fba_req_if.sink              in_ch,
  fba_rsp_if.source            out_ch,
  output fba_pkg::ram_wr_t     ram_wr,
  output fba_pkg::ram_rd_t     ram_rd,
  input  wire fba_pkg::word_t  ram_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_RESP
  } state_t;

  state_t                      state_r;
  fba_pkg::waddr_t             clr_addr_r;
  fba_pkg::req_kind_t          kind_r;
  fba_pkg::bitpos_t            bit_r;
  fba_pkg::waddr_t             word_r;
  fba_pkg::count_t             count_r;

  logic                        res_used_r;
  logic                        res_found_r;
  logic [fba_pkg::ADDR_W-1:0]  res_addr_r;
  logic                        res_oor_r;

  logic                        out_valid_r;
  logic                        out_used_r;
  logic                        out_found_r;
  logic [fba_pkg::ADDR_W-1:0]  out_addr_r;
  fba_pkg::count_t             out_count_r;
  logic                        out_oor_r;

  logic [fba_pkg::AIDX_W-1:0]  req_aidx;
  fba_pkg::fidx_t              req_idx;
  logic                        req_oor;
  logic                        accept;
  fba_pkg::word_t              bit_sel;
  logic                        cur_bit;
  fba_pkg::free_hit_t          hit;
  fba_pkg::bitpos_t            scan_low;
  fba_pkg::fidx_t              hit_idx;
  logic [fba_pkg::ADDR_W-1:0]  hit_addr;
  logic                        out_free;

  // Decode of the incoming request.
  always_comb begin
    req_aidx = in_ch.request_address[fba_pkg::ADDR_W-1:fba_pkg::FRAME_SHIFT];
    req_idx  = req_aidx[fba_pkg::FIDX_W-1:0];
    req_oor  = ({1'b0, req_aidx} >= fba_pkg::FRAME_LIMIT);
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Bit of the addressed frame and the first free bit in the word just read.
  always_comb begin
    bit_sel  = fba_pkg::word_t'(1) << bit_r;
    cur_bit  = ram_data[bit_r];
    scan_low = (state_r == ST_READ) ? bit_r : '0;
    hit      = fba_pkg::first_free(ram_data, scan_low);
    hit_idx  = {word_r, hit.pos};
    hit_addr = fba_pkg::ADDR_W'(hit_idx) << fba_pkg::FRAME_SHIFT;
  end

  // Memory commands: clearing writes, request reads, write-back of marks, scan reads.
  always_comb begin
    ram_wr = '0;
    ram_rd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = clr_addr_r;
        ram_wr.data = fba_pkg::WORD_ALL_USED;
      end
      ST_IDLE: begin
        ram_rd.en   = accept && !req_oor;
        ram_rd.addr = req_idx[fba_pkg::FIDX_W-1:fba_pkg::BIT_W];
      end
      ST_READ, ST_SCAN: begin
        if (state_r == ST_READ && kind_r == fba_pkg::REQ_RESERVE && !cur_bit) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = word_r;
          ram_wr.data = ram_data | bit_sel;
        end else if (state_r == ST_READ && kind_r == fba_pkg::REQ_RELEASE && cur_bit) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = word_r;
          ram_wr.data = ram_data & ~bit_sel;
        end
        ram_rd.en   = (kind_r == fba_pkg::REQ_FIND) && !hit.hit && (word_r != fba_pkg::LAST_WORD);
        ram_rd.addr = word_r + 1'b1;
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // State, counter and the response registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= fba_pkg::COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      // A taken response is dropped unless the next one is loaded in this cycle.
      if (out_valid_r && out_ch.ready && state_r != ST_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == fba_pkg::LAST_WORD) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            kind_r      <= fba_pkg::req_kind_t'(in_ch.req_type);
            bit_r       <= req_idx[fba_pkg::BIT_W-1:0];
            word_r      <= req_idx[fba_pkg::FIDX_W-1:fba_pkg::BIT_W];
            res_used_r  <= 1'b0;
            res_found_r <= 1'b0;
            res_addr_r  <= '0;
            res_oor_r   <= req_oor;
            state_r     <= req_oor ? ST_RESP : ST_READ;
          end
        end
        ST_READ, ST_SCAN: begin
          if (state_r == ST_READ) begin
            res_used_r <= cur_bit;
          end
          unique case (kind_r)
            fba_pkg::REQ_TEST: begin
              state_r <= ST_RESP;
            end
            fba_pkg::REQ_RESERVE: begin
              if (!cur_bit) begin
                count_r <= count_r + 1'b1;
              end
              state_r <= ST_RESP;
            end
            fba_pkg::REQ_RELEASE: begin
              if (cur_bit) begin
                count_r <= count_r - 1'b1;
              end
              state_r <= ST_RESP;
            end
            fba_pkg::REQ_FIND: begin
              if (hit.hit) begin
                res_found_r <= 1'b1;
                res_addr_r  <= hit_addr;
                state_r     <= ST_RESP;
              end else if (word_r == fba_pkg::LAST_WORD) begin
                state_r <= ST_RESP;
              end else begin
                word_r  <= word_r + 1'b1;
                state_r <= ST_SCAN;
              end
            end
            default: begin
              state_r <= ST_RESP;
            end
          endcase
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_used_r  <= res_used_r;
            out_found_r <= res_found_r;
            out_addr_r  <= res_addr_r;
            out_count_r <= count_r;
            out_oor_r   <= res_oor_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_used   = out_used_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.free_address = out_addr_r;
  assign out_ch.used_count   = out_count_r;
  assign out_ch.out_of_range = out_oor_r;

endmodule

`default_nettype wire

// ----- hdl/frame_bitmap_allocator.sv -----
// Top level of the page-frame bitmap allocator: sequencer plus bitmap memory.
//
//   Channel  Port    Direction  Contents
//   request  in_ch   sink       req_type, request_address
//   response out_ch  source     frame_used, found, free_address, used_count, out_of_range
//
// Test and mark requests pass through accept, memory read and response load.
// Find goes on past the memory read with one scan read per further bitmap word, up to
// the last word, the single read port walking one 8-bit word each cycle.
// After reset a clearing pass writes all 8192 words as used, with ready low.
// A response waits in the output register; the next request is taken meanwhile.
`default_nettype none

module frame_bitmap_allocator (
  input  wire        clk,
  input  wire        rst_n,
  fba_req_if.sink    in_ch,
  fba_rsp_if.source  out_ch
);

  fba_pkg::ram_wr_t ram_wr;
  fba_pkg::ram_rd_t ram_rd;
  fba_pkg::word_t   ram_data;

  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .ram_wr   (ram_wr),
    .ram_rd   (ram_rd),
    .ram_data (ram_data)
  );

  fba_map_ram u_map (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_data)
  );

endmodule

`default_nettype wire
